@@ rtl/gm3_pkg.sv @@
// shared types, codes and helpers for the 3x3 grayscale morphology block
package gm3_pkg;

    localparam int PIX_BITS = 8;
    localparam logic [PIX_BITS-1:0] PIX_MAX = '1;
    localparam int CFG_BITS = 11;

    typedef logic [PIX_BITS-1:0] t_pix;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_MASK   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    function automatic t_pix pick(input t_pix a, input t_pix b, input logic dil);
        if (dil) begin
            pick = (a > b) ? a : b;
        end else begin
            pick = (a < b) ? a : b;
        end
    endfunction

endpackage

@@ rtl/gm3_ram.sv @@
// simple dual-port ram with registered, read-first output
module gm3_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gm3_cell.sv @@
// one morphology cell: two line buffers, 3x3 window and masked max/min reduction
module gm3_cell
    import gm3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h,
    input  logic [8:0]                        i_mask,
    input  logic                              i_dil,
    input  logic                              i_valid,
    input  t_pix                              i_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_x,
    input  logic [$clog2(MAX_HEIGHT+4)-1:0]   i_y,
    output logic                              o_valid,
    output t_pix                              o_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_x,
    output logic [$clog2(MAX_HEIGHT+4)-1:0]   o_y
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int YW = $clog2(MAX_HEIGHT+4);

    logic          acc_in;
    logic          we2;
    t_pix          lb1_q;
    t_pix          lb2_q;
    t_pix          row0_new;

    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    logic          r_byp;
    t_pix          r_byp_d;

    t_pix          r_win [3][3];
    logic          r_s2_valid;
    logic [XW-1:0] r_s2_x;
    logic [YW-1:0] r_s2_y;

    logic          r_s3_valid;
    t_pix          r_s3_row [3];
    logic [XW-1:0] r_s3_x;
    logic [YW-1:0] r_s3_y;

    logic          r_o_valid;
    t_pix          r_o_pix;
    logic [XW-1:0] r_o_x;
    logic [YW-1:0] r_o_y;

    logic          xpos;
    logic          cval;
    logic [XW-1:0] xc;
    logic [YW-1:0] yc;
    logic [2:0]    colok;
    logic [2:0]    rowok;
    t_pix          tap [3][3];
    t_pix          row_red [3];

    assign acc_in = i_valid & i_adv;
    assign we2    = r_s1_valid & i_adv;

    gm3_ram #(.DW(PIX_BITS), .DEPTH(MAX_WIDTH)) u_lb1 (
        .i_clk   (i_clk),
        .i_we    (acc_in),
        .i_waddr (i_x),
        .i_wdata (i_pix),
        .i_re    (acc_in),
        .i_raddr (i_x),
        .o_rdata (lb1_q)
    );

    gm3_ram #(.DW(PIX_BITS), .DEPTH(MAX_WIDTH)) u_lb2 (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_s1_x),
        .i_wdata (lb1_q),
        .i_re    (acc_in),
        .i_raddr (i_x),
        .o_rdata (lb2_q)
    );

    assign row0_new = r_byp ? r_byp_d : lb2_q;

    // centre position lies w+1 words behind the incoming one
    assign xpos = (r_s1_x != '0);
    assign cval = (r_s1_y >= YW'(2)) || ((r_s1_y == YW'(1)) && xpos);
    assign xc   = xpos ? (r_s1_x - 1'b1) : XW'(i_w - 1'b1);
    assign yc   = xpos ? (r_s1_y - 1'b1) : (r_s1_y - YW'(2));

    // stage a/b: pixel registers and window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid & cval;
            if (acc_in) begin
                r_byp <= we2 && (i_x == r_s1_x);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (acc_in) begin
                r_s1_pix <= i_pix;
                r_s1_x   <= i_x;
                r_s1_y   <= i_y;
                r_byp_d  <= lb1_q;
            end
            if (r_s1_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= row0_new;
                r_win[1][2] <= lb1_q;
                r_win[2][2] <= r_s1_pix;
                r_s2_x      <= xc;
                r_s2_y      <= yc;
            end
        end
    end

    // stage c: border and mask selection, row reduction
    assign colok[0] = (r_s2_x != '0);
    assign colok[1] = 1'b1;
    assign colok[2] = ((WW'(r_s2_x) + 1'b1) < i_w);
    assign rowok[0] = (r_s2_y != '0);
    assign rowok[1] = (r_s2_y < YW'(i_h));
    assign rowok[2] = ((r_s2_y + 1'b1) < YW'(i_h));

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!i_mask[r*3+c]) begin
                    tap[r][c] = i_dil ? '0 : PIX_MAX;
                end else if (rowok[r] && colok[c]) begin
                    tap[r][c] = r_win[r][c];
                end else begin
                    tap[r][c] = '0;
                end
            end
            row_red[r] = pick(pick(tap[r][0], tap[r][1], i_dil), tap[r][2], i_dil);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (i_adv) begin
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_row <= row_red;
            r_s3_x   <= r_s2_x;
            r_s3_y   <= r_s2_y;
            r_o_pix  <= pick(pick(r_s3_row[0], r_s3_row[1], i_dil), r_s3_row[2], i_dil);
            r_o_x    <= r_s3_x;
            r_o_y    <= r_s3_y;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pix   = r_o_pix;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
endmodule

@@ rtl/grayscale_morphology_3x3.sv @@
// 3x3 grayscale morphology (dilation, erosion, opening, closing) on a pixel stream
//
// Takes one word per clock, pixels of a frame in raster order, and gives one result word
// per frame position in raster order, with tlast on the last position of the frame. A
// result for position p leaves after the input word at position p+w+1 (dilation, erosion)
// or p+2w+2 (opening, closing) has been taken. On its way it is registered in the stages
// of one cell (dilation, erosion) or of both cells (opening, closing), then in the output
// register. After the last pixel, flush words (tuser high) push the remaining results out,
// one per flush. When a frame has fewer positions than that lag, tready drops once the last
// pixel is in, while the missing positions (at most w+2) are filled without input, so that
// every later flush gives one result. Throughput is one word per cycle, set by the chain of
// two cells, each with two line buffer rams of max_width entries, a 3x3 window and a
// two-stage reduction tree; apart from that gap the chain stalls only while the output
// register holds a word that is not taken.
module grayscale_morphology_3x3
    import gm3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // pixel_in
    input  logic [0:0]          i_s_axis_tuser,   // cmd
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,   // pixel_out
    output logic                o_m_axis_tlast,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int YW = $clog2(MAX_HEIGHT+4);
    localparam int QW = $clog2(MAX_WIDTH*MAX_HEIGHT + 2*MAX_WIDTH + 4);

    logic [10:0]   r_width;
    logic [10:0]   r_height;
    t_mode         r_mode;
    logic [8:0]    r_mask;

    logic [XW-1:0] r_qx;
    logic [YW-1:0] r_qy;
    logic [QW-1:0] r_qcnt;
    logic [XW-1:0] r_ox;
    logic [YW-1:0] r_oy;

    logic          r_o_valid;
    t_pix          r_o_pix;
    logic          r_o_last;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [QW-1:0] delay;
    logic          adv;
    logic          pad;
    logic          acc;
    logic          in_frame;
    logic          advance;
    logic          emit;
    logic          last;
    logic          dil0;
    logic          dil1;

    logic          c0_valid;
    t_pix          c0_pix;
    logic [XW-1:0] c0_x;
    logic [YW-1:0] c0_y;
    logic          c1_valid;
    t_pix          c1_pix;
    logic [XW-1:0] c1_x;
    logic [YW-1:0] c1_y;
    logic          sel_valid;
    t_pix          sel_pix;
    logic [XW-1:0] sel_x;
    logic [YW-1:0] sel_y;

    assign w = (r_width == '0) ? WW'(1) :
               ((32'(r_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_width));
    assign h = (r_height == '0) ? HW'(1) :
               ((32'(r_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_height));
    assign delay = r_mode[1] ? ((QW'(w) << 1) + QW'(2)) : (QW'(w) + QW'(1));

    // frame shorter than the delay: fill the missing positions without input
    assign adv      = !r_o_valid || i_m_axis_tready;
    assign in_frame = (r_qy < YW'(h));
    assign pad      = !in_frame && (r_qcnt < delay);
    assign acc      = i_s_axis_tvalid && adv && !pad;
    assign advance  = (adv && pad) ||
                      (acc && (((i_s_axis_tuser[0] == CMD_PIXEL) && in_frame) ||
                               ((i_s_axis_tuser[0] == CMD_FLUSH) && !in_frame)));
    assign emit     = advance && (r_qcnt >= delay);
    assign last     = emit && (WW'(r_ox) == w - 1'b1) && (r_oy == YW'(h - 1'b1));

    assign dil0 = (r_mode == MODE_DILATE) || (r_mode == MODE_CLOSE);
    assign dil1 = (r_mode == MODE_OPEN);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd20;
            r_height <= 11'd20;
            r_mode   <= MODE_DILATE;
            r_mask   <= 9'd186;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_MASK:   r_mask   <= i_cfg_data[8:0];
                default:    r_mask   <= r_mask;
            endcase
        end
    end

    // input and output position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || last) begin
            r_qx   <= '0;
            r_qy   <= '0;
            r_qcnt <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
        end else if (advance) begin
            r_qcnt <= r_qcnt + 1'b1;
            if (WW'(r_qx) == w - 1'b1) begin
                r_qx <= '0;
                r_qy <= r_qy + 1'b1;
            end else begin
                r_qx <= r_qx + 1'b1;
            end
            if (emit) begin
                if (WW'(r_ox) == w - 1'b1) begin
                    r_ox <= '0;
                    r_oy <= r_oy + 1'b1;
                end else begin
                    r_ox <= r_ox + 1'b1;
                end
            end
        end
    end

    gm3_cell #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_w     (w),
        .i_h     (h),
        .i_mask  (r_mask),
        .i_dil   (dil0),
        .i_valid (advance),
        .i_pix   (i_s_axis_tdata),
        .i_x     (r_qx),
        .i_y     (r_qy),
        .o_valid (c0_valid),
        .o_pix   (c0_pix),
        .o_x     (c0_x),
        .o_y     (c0_y)
    );

    gm3_cell #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_w     (w),
        .i_h     (h),
        .i_mask  (r_mask),
        .i_dil   (dil1),
        .i_valid (c0_valid),
        .i_pix   (c0_pix),
        .i_x     (c0_x),
        .i_y     (c0_y),
        .o_valid (c1_valid),
        .o_pix   (c1_pix),
        .o_x     (c1_x),
        .o_y     (c1_y)
    );

    assign sel_valid = r_mode[1] ? c1_valid : c0_valid;
    assign sel_pix   = r_mode[1] ? c1_pix   : c0_pix;
    assign sel_x     = r_mode[1] ? c1_x     : c0_x;
    assign sel_y     = r_mode[1] ? c1_y     : c0_y;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= sel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_pix  <= sel_pix;
            r_o_last <= (WW'(sel_x) == w - 1'b1) && (sel_y == YW'(h - 1'b1));
        end
    end

    assign o_s_axis_tready = adv && !pad;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_pix;
    assign o_m_axis_tlast  = r_o_last;
endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the 3x3 grayscale morphology block
`timescale 1ns / 100ps

module testbench;
    import gm3_pkg::*;

    class morph_scoreboard;
        byte unsigned   frame_pix[];
        logic [10:0]    width_reg, height_reg;
        t_mode          mode_reg;
        logic [8:0]     mask_reg;
        int             col, row, emitted;
        t_pix           pix_q[$];
        logic           last_q[$];
        int             mismatches;

        function new();
            frame_pix = new[1024 * 1024];
            width_reg = 11'd20;
            height_reg = 11'd20;
            mode_reg = MODE_DILATE;
            mask_reg = 9'd186;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            col = 0;
            row = 0;
            emitted = 0;
        endfunction

        function int frame_w();
            return (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : int'(width_reg);
        endfunction

        function int frame_h();
            return (height_reg == 0) ? 1 : (height_reg > 1024) ? 1024 : int'(height_reg);
        endfunction

        function bit in_frame(int x, int y);
            return x >= 0 && y >= 0 && x < frame_w() && y < frame_h();
        endfunction

        function int reduce_src(int x, int y, bit dil);
            int acc, v;
            acc = dil ? 0 : 255;
            for (int b = 0; b < 9; b++) begin
                if (mask_reg[b]) begin
                    v = in_frame(x + b % 3 - 1, y + b / 3 - 1) ?
                        frame_pix[(y + b / 3 - 1) * frame_w() + x + b % 3 - 1] : 0;
                    if (dil ? v > acc : v < acc) acc = v;
                end
            end
            return acc;
        endfunction

        function int reduce_mid(int x, int y, bit dil1, bit dil2);
            int acc, v;
            acc = dil2 ? 0 : 255;
            for (int b = 0; b < 9; b++) begin
                if (mask_reg[b]) begin
                    v = in_frame(x + b % 3 - 1, y + b / 3 - 1) ?
                        reduce_src(x + b % 3 - 1, y + b / 3 - 1, dil1) : 0;
                    if (dil2 ? v > acc : v < acc) acc = v;
                end
            end
            return acc;
        endfunction

        function void produce();
            int x, y, v;
            bit last;
            x = emitted % frame_w();
            y = emitted / frame_w();
            last = (emitted == frame_w() * frame_h() - 1);
            case (mode_reg)
                MODE_DILATE: v = reduce_src(x, y, 1);
                MODE_ERODE:  v = reduce_src(x, y, 0);
                MODE_OPEN:   v = reduce_mid(x, y, 0, 1);
                default:     v = reduce_mid(x, y, 1, 0);
            endcase
            pix_q = {pix_q, t_pix'(v)};
            last_q = {last_q, logic'(last)};
            emitted++;
            if (last) restart();
        endfunction

        function void note_config(t_cfg_idx idx, logic [10:0] val);
            case (idx)
                CFG_WIDTH:  width_reg = val;
                CFG_HEIGHT: height_reg = val;
                CFG_MODE:   mode_reg = t_mode'(val[1:0]);
                default:    mask_reg = val[8:0];
            endcase
            restart();
        endfunction

        function void note_word(logic cmd, t_pix pix);
            int w, h, q, lag;
            w = frame_w();
            h = frame_h();
            lag = (mode_reg == MODE_OPEN || mode_reg == MODE_CLOSE) ? 2 * w + 2 : w + 1;
            if (col >= w || row > h) restart();
            if (cmd == CMD_PIXEL) begin
                if (row >= h) return;
                q = row * w + col;
                frame_pix[q] = pix;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
                if (q >= lag && emitted == q - lag) produce();
            end else if (row >= h && emitted < w * h) begin
                produce();
            end
        endfunction

        function int left_in_frame();
            return (row >= frame_h()) ? frame_w() * frame_h() - emitted : 0;
        endfunction

        function void check_result(t_pix pix, logic last);
            t_pix ep;
            logic el;
            if (pix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pixel %0d last %0b", pix, last);
                return;
            end
            ep = pix_q.pop_front();
            el = last_q.pop_front();
            if (ep !== pix || el !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                             ep, el, pix, last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [7:0]          i_s_axis_tdata;
    logic [0:0]          i_s_axis_tuser;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [7:0]          o_m_axis_tdata;
    logic                o_m_axis_tlast;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [CFG_BITS-1:0] i_cfg_data;

    morph_scoreboard sb;
    bit  calm;
    int  pixels_sent;
    int  idle_cycles;
    bit  s_taken, m_taken;

    grayscale_morphology_3x3 u_dut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: random stall bursts
    initial begin
        int burst;
        i_m_axis_tready = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 19);
                i_m_axis_tready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // results are taken at the next edge; inputs are stable at the falling edge
    always @(negedge i_clk) begin
        m_taken = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        s_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (m_taken) sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || s_taken || m_taken || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 5000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_word(logic cmd, t_pix pix);
        bit ready;
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= pix;
        do begin
            @(negedge i_clk);
            ready = o_s_axis_tready;
            @(posedge i_clk);
        end while (!ready);
        sb.note_word(cmd, pix);
        if (cmd == CMD_PIXEL) pixels_sent++;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pix_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [10:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.note_config(idx, val);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_pix any_pixel();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return t_pix'($urandom);
        endcase
    endfunction

    task automatic run_frame(logic [10:0] w, logic [10:0] h, t_mode m, logic [8:0] mask,
                             bit abandon);
        int n, stop_at;
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_MODE, 11'(m));
        write_reg(CFG_MASK, 11'(mask));
        n = sb.frame_w() * sb.frame_h();
        stop_at = abandon ? int'($urandom_range(0, n - 1)) : n;
        for (int i = 0; i < stop_at; i++) begin
            if ($urandom_range(0, 15) == 0) send_word(CMD_FLUSH, any_pixel());
            send_word(CMD_PIXEL, any_pixel());
        end
        if (abandon) begin
            drain();
            return;
        end
        if ($urandom_range(0, 2) == 0) send_word(CMD_PIXEL, any_pixel());
        while (sb.left_in_frame() > 0) send_word(CMD_FLUSH, any_pixel());
    endtask

    initial begin
        t_mode m;
        sb = new();
        calm = 1'b0;
        pixels_sent = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = CMD_PIXEL;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flush too early, extremes, stray pixel after frame, empty mask
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'd2);
        write_reg(CFG_MODE, 11'(MODE_DILATE));
        write_reg(CFG_MASK, 11'h1ff);
        send_word(CMD_FLUSH, 8'hff);
        send_word(CMD_PIXEL, 8'd0);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_PIXEL, 8'd1);
        send_word(CMD_PIXEL, 8'd128);
        send_word(CMD_PIXEL, 8'd254);
        send_word(CMD_PIXEL, 8'd255);
        send_word(CMD_PIXEL, 8'd77);
        while (sb.left_in_frame() > 0) send_word(CMD_FLUSH, 8'd0);
        run_frame(11'd2, 11'd2, MODE_ERODE, 9'h000, 1'b0);
        run_frame(11'd2, 11'd1, MODE_OPEN, 9'h1ff, 1'b0);
        run_frame(11'd0, 11'd0, MODE_CLOSE, 9'h1ff, 1'b0);

        // abandoned frame: sender stops at a random pixel and holds off until every result is out
        run_frame(11'd4, 11'd3, MODE_CLOSE, 9'd186, 1'b1);
        drain();

        run_frame(11'd40, 11'd2, MODE_DILATE, 9'h1ff, 1'b0);
        run_frame(11'd1, 11'd30, MODE_OPEN, 9'h0aa, 1'b0);

        while (pixels_sent < 650) begin
            m = t_mode'($urandom_range(0, 3));
            if (pixels_sent > 580) calm = 1'b1;
            run_frame(11'($urandom_range(1, 9)), 11'($urandom_range(1, 7)), m,
                      9'($urandom_range(0, 511)), $urandom_range(0, 7) == 0);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pix_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
